@@ rtl/core/rod_pkg.sv @@
package rod_pkg;

  // Dither matrix select codes
  localparam logic [3:0] DT_THREE_LEVEL = 4'd1;
  localparam logic [3:0] DT_TWO         = 4'd2;
  localparam logic [3:0] DT_THREE       = 4'd3;
  localparam logic [3:0] DT_FOUR        = 4'd4;
  localparam logic [3:0] DT_EIGHT       = 4'd8;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_DITHER_TYPE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [3:0]  DITHER_TYPE_RST  = 4'd0;
  localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd128;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd64;

  localparam logic [7:0] THR_SINGLE = 8'h80;

  localparam logic [7:0] THR_THREE_LEVEL [4] = '{8'hAA, 8'h55, 8'h55, 8'hAA};
  localparam logic [7:0] THR_TWO [4] = '{8'h33, 8'h99, 8'hCC, 8'h66};
  localparam logic [7:0] THR_THREE [9] = '{
    8'h4C, 8'hCC, 8'h66, 8'h99, 8'h19, 8'hE5, 8'h33, 8'hB2, 8'h7F};
  localparam logic [7:0] THR_FOUR [16] = '{
    8'h0F, 8'h87, 8'h2D, 8'hA5, 8'hC3, 8'h4B, 8'hE1, 8'h69,
    8'h3C, 8'hB4, 8'h1E, 8'h96, 8'hF0, 8'h78, 8'hD2, 8'h5A};
  localparam logic [7:0] THR_EIGHT [64] = '{
    8'h03, 8'hC0, 8'h33, 8'hF0, 8'h0F, 8'hCC, 8'h3F, 8'hFC,
    8'h81, 8'h42, 8'hB1, 8'h72, 8'h8D, 8'h4E, 8'hBD, 8'h7E,
    8'h23, 8'hE0, 8'h13, 8'hD0, 8'h2F, 8'hEC, 8'h1F, 8'hDC,
    8'hA1, 8'h62, 8'h91, 8'h52, 8'hAD, 8'h6E, 8'h9D, 8'h5E,
    8'h0B, 8'hC8, 8'h3B, 8'hF8, 8'h07, 8'hC4, 8'h37, 8'hF4,
    8'h89, 8'h4A, 8'hB9, 8'h7A, 8'h85, 8'h46, 8'hB5, 8'h76,
    8'h2B, 8'hE8, 8'h1B, 8'hD8, 8'h27, 8'hE4, 8'h17, 8'hD4,
    8'hA9, 8'h6A, 8'h99, 8'h5A, 8'hA5, 8'h66, 8'h95, 8'h56};

  typedef struct packed {
    logic [3:0]  dither_type;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } rod_cfg_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic       frame_end;
  } rod_pos_t;

  // Matrix side length; 1 for the single threshold
  function automatic logic [3:0] matrix_size(input logic [3:0] dtype);
    logic [3:0] size;
    case (dtype)
      DT_THREE_LEVEL: size = 4'd2;
      DT_TWO:         size = 4'd2;
      DT_THREE:       size = 4'd3;
      DT_FOUR:        size = 4'd4;
      DT_EIGHT:       size = 4'd8;
      default:        size = 4'd1;
    endcase
    return size;
  endfunction

  // ty/tx are already inside the matrix
  function automatic logic [7:0] threshold_at(input logic [3:0] dtype,
                                              input logic [2:0] ty,
                                              input logic [2:0] tx);
    logic [7:0] thr;
    logic [3:0] idx3;
    idx3 = 4'({ty[1:0], 1'b0}) + 4'(ty[1:0]) + 4'(tx[1:0]);
    case (dtype)
      DT_THREE_LEVEL: thr = THR_THREE_LEVEL[{ty[0], tx[0]}];
      DT_TWO:         thr = THR_TWO[{ty[0], tx[0]}];
      DT_THREE:       thr = (idx3 < 4'd9) ? THR_THREE[idx3] : THR_THREE[0];
      DT_FOUR:        thr = THR_FOUR[{ty[1:0], tx[1:0]}];
      DT_EIGHT:       thr = THR_EIGHT[{ty, tx}];
      default:        thr = THR_SINGLE;
    endcase
    return thr;
  endfunction

endpackage

@@ rtl/core/rod_if.sv @@
interface rod_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rod_result_if;
  logic valid;
  logic ready;
  logic lit;
  logic frame_end;

  modport source (output valid, output lit, output frame_end, input ready);
  modport sink   (input valid, input lit, input frame_end, output ready);
endinterface

@@ rtl/core/rod_position.sv @@
// Raster position and matrix phase tracking; threshold lookup for the
// current pixel.
module rod_position #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rod_pkg::rod_cfg_t cfg,
  output rod_pkg::rod_pos_t pos
);

  localparam int CNTW = $clog2(MAX_DIMENSION);
  localparam int BNDW = CNTW + 1;

  logic [CNTW-1:0] column_count;
  logic [CNTW-1:0] row_count;
  logic [2:0]      column_phase;
  logic [2:0]      row_phase;

  logic [3:0]      size;
  logic [31:0]     w_ext;
  logic [31:0]     h_ext;
  logic [BNDW-1:0] w_bound;
  logic [BNDW-1:0] h_bound;
  logic [BNDW-1:0] col_inc;
  logic [BNDW-1:0] row_inc;
  logic [3:0]      cph_inc;
  logic [3:0]      rph_inc;
  logic [2:0]      tx;
  logic [2:0]      ty;
  logic            row_end;
  logic            last_row;

  assign size  = rod_pkg::matrix_size(cfg.dither_type);
  assign w_ext = 32'(cfg.image_width);
  assign h_ext = 32'(cfg.image_height);

  // zero acts as one, oversize saturates
  always_comb begin
    if (w_ext == 32'd0) begin
      w_bound = BNDW'(1);
    end else if (w_ext > 32'(MAX_DIMENSION)) begin
      w_bound = BNDW'(MAX_DIMENSION);
    end else begin
      w_bound = BNDW'(w_ext);
    end
    if (h_ext == 32'd0) begin
      h_bound = BNDW'(1);
    end else if (h_ext > 32'(MAX_DIMENSION)) begin
      h_bound = BNDW'(MAX_DIMENSION);
    end else begin
      h_bound = BNDW'(h_ext);
    end
  end

  assign col_inc  = {1'b0, column_count} + BNDW'(1);
  assign row_inc  = {1'b0, row_count} + BNDW'(1);
  assign row_end  = (col_inc >= w_bound);
  assign last_row = (row_inc >= h_bound);
  assign cph_inc  = {1'b0, column_phase} + 4'd1;
  assign rph_inc  = {1'b0, row_phase} + 4'd1;

  // phase left outside a smaller matrix looks up index 0
  assign tx = ({1'b0, column_phase} < size) ? column_phase : 3'd0;
  assign ty = ({1'b0, row_phase} < size) ? row_phase : 3'd0;

  assign pos.threshold = rod_pkg::threshold_at(cfg.dither_type, ty, tx);
  assign pos.frame_end = row_end && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      column_phase <= '0;
      row_phase    <= '0;
    end else if (advance) begin
      if (row_end) begin
        column_count <= '0;
        column_phase <= '0;
        if (last_row) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= CNTW'(row_inc);
          row_phase <= (rph_inc >= size) ? 3'd0 : rph_inc[2:0];
        end
      end else begin
        column_count <= CNTW'(col_inc);
        column_phase <= (cph_inc >= size) ? 3'd0 : cph_inc[2:0];
      end
    end
  end

endmodule

@@ rtl/core/rod_luma.sv @@
// Fixed-point luminance: (19661 r + 38666 g + 7209 b) >> 16.
module rod_luma (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] luma
);

  localparam logic [15:0] WEIGHT_R = 16'd19661;
  localparam logic [15:0] WEIGHT_G = 16'd38666;
  localparam logic [15:0] WEIGHT_B = 16'd7209;

  logic [23:0] sum;

  // weights sum to 65536, so the sum stays below 2^24
  assign sum = 24'(WEIGHT_R * 24'(red)) + 24'(WEIGHT_G * 24'(green))
             + 24'(WEIGHT_B * 24'(blue));
  assign luma = sum[23:16];

endmodule

@@ rtl/core/rgb_ordered_dither_unit.sv @@
// Ordered-dither binarizer for an RGB888 pixel stream in raster order. Each
// item on pixels yields one item on results: lit is 1 when the pixel's
// luminance (19661 r + 38666 g + 7209 b) >> 16 is at least the threshold of
// the selected dither matrix at the current row/column phase, and frame_end
// marks the last pixel of the frame. dither_type 1, 2, 3, 4, 8 select the
// 2x2 three-level, 2x2, 3x3, 4x4 and 8x8 matrices; any other code compares
// against 0x80. Position wraps at image_width and image_height; a zero size
// acts as one and a size above MAX_DIMENSION saturates. Rate is one item per
// clock unless results.ready stalls it. The threshold lookup sits between the
// input and the stage-1 register, the luminance and compare between stage 1
// and the result register. pixels.ready follows results.ready through the
// two stage-valid bits, so a stalled result blocks input only once both
// stages are full. Write configuration only while no item is in flight;
// changes take effect from the next item accepted.
module rgb_ordered_dither_unit #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  rod_pixel_if.sink                         pixels,
  rod_result_if.source                      results,
  input  logic                              cfg_write,
  input  logic [rod_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rod_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  rod_pkg::rod_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dither_type  <= rod_pkg::DITHER_TYPE_RST;
      cfg.image_width  <= rod_pkg::IMAGE_WIDTH_RST;
      cfg.image_height <= rod_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        rod_pkg::CFG_DITHER_TYPE:  cfg.dither_type  <= cfg_data[3:0];
        rod_pkg::CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        rod_pkg::CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default: ; // unmapped index: write ignored
      endcase
    end
  end

  // handshake: each stage advances when the stage after it is empty or
  // draining this cycle
  logic s1_valid;
  logic s2_ready;
  logic s1_ready;
  logic accept;

  assign s2_ready     = !results.valid || results.ready;
  assign s1_ready     = !s1_valid || s2_ready;
  assign pixels.ready = s1_ready;
  assign accept       = pixels.valid && s1_ready;

  // position state advances once per accepted item
  rod_pkg::rod_pos_t pos;

  rod_position #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_position (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .cfg     (cfg),
    .pos     (pos)
  );

  // stage 1: pixel plus its threshold and frame flag
  logic [7:0]        s1_red;
  logic [7:0]        s1_green;
  logic [7:0]        s1_blue;
  rod_pkg::rod_pos_t s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red   <= pixels.red;
      s1_green <= pixels.green;
      s1_blue  <= pixels.blue;
      s1_pos   <= pos;
    end
  end

  // stage 2: luminance compare into the result register
  logic [7:0] luma;

  rod_luma u_luma (
    .red   (s1_red),
    .green (s1_green),
    .blue  (s1_blue),
    .luma  (luma)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s2_ready) begin
      results.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      results.lit       <= (luma >= s1_pos.threshold);
      results.frame_end <= s1_pos.frame_end;
    end
  end

  // stage 1 moving forward always lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> results.valid)
    else $error("stage-1 item lost on its way to the result register");

  // a stalled stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_pos))
    else $error("stage-1 item changed while stalled");

  // a one-pixel frame ends on every pixel
  a_unit_frame: assert property (@(posedge clk) disable iff (rst)
    (cfg.image_width <= 13'd1) && (cfg.image_height <= 13'd1) |-> pos.frame_end)
    else $error("frame_end missing for a one-pixel frame");

endmodule

@@ verif/tb_rgb_ordered_dither_unit.sv @@
`timescale 1ns / 1ps

module tb_rgb_ordered_dither_unit;

  // Any code outside the matrix set falls back to the single 0x80 threshold
  localparam logic [3:0] DT_PLAIN = 4'd15;

  localparam int RANDOM_ITEMS = 1250;
  // Pipeline is two deep; extra drain time after the last result
  localparam int DRAIN_CYCLES = 8;
  // Watchdog: ~1300 items at worst-case gap + stall, several times over
  localparam int WATCHDOG_NS = 5_000_000;
  // Receiver holds off once, after this many results and while the input is
  // stalled, so the pipe stays full with the sender still offering
  localparam int BACKPRESSURE_AT = 400;
  localparam int BACKPRESSURE_LEN = 80;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic lit;
    logic frame_end;
  } dot_t;

  typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

  // Directed table: either a register write or a pixel. For a pixel, typed
  // means lit/frame_end are given here; otherwise the predictor decides.
  typedef struct packed {
    row_kind_t                         kind;
    logic [rod_pkg::CFG_INDEX_W-1:0]   index;
    logic [rod_pkg::CFG_DATA_W-1:0]    value;
    logic [7:0]                        red;
    logic [7:0]                        green;
    logic [7:0]                        blue;
    logic                              typed;
    logic                              lit;
    logic                              frame_end;
  } plan_row_t;

  localparam int PLAN_ROWS = 35;
  // index is unused on pixel rows
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset settings: plain 0x80 threshold, 128 x 64 frame
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd127, 8'd127, 8'd127, 1'b1, 1'b0, 1'b0},
    // zero size acts as one: every pixel ends a frame
    '{ROW_WRITE, rod_pkg::CFG_IMAGE_WIDTH, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_IMAGE_HEIGHT, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b1},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0, 1'b1},
    // oversized sizes saturate
    '{ROW_WRITE, rod_pkg::CFG_IMAGE_WIDTH, 13'd8191, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_IMAGE_HEIGHT, 13'd8191, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_DITHER_TYPE, 13'(rod_pkg::DT_EIGHT),
      8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd200, 8'd40, 8'd90, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd16, 8'd16, 8'd16, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd90, 8'd180, 8'd30, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0},
    // mid-row switch to 3x3: column phase 4 lies outside the matrix
    '{ROW_WRITE, rod_pkg::CFG_DITHER_TYPE, 13'(rod_pkg::DT_THREE),
      8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd60, 8'd120, 8'd200, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd77, 8'd77, 8'd77, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_DITHER_TYPE, 13'(rod_pkg::DT_THREE_LEVEL),
      8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd170, 8'd170, 8'd170, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd84, 8'd84, 8'd84, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_DITHER_TYPE, 13'(rod_pkg::DT_TWO),
      8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd153, 8'd153, 8'd153, 1'b0, 1'b0, 1'b0},
    // shrink below the current column: wraps on next pixel, then row and
    // frame restarts inside a 3 x 2 frame
    '{ROW_WRITE, rod_pkg::CFG_IMAGE_WIDTH, 13'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_IMAGE_HEIGHT, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_DITHER_TYPE, 13'(rod_pkg::DT_FOUR),
      8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd15, 8'd15, 8'd15, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd134, 8'd134, 8'd134, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd45, 8'd45, 8'd45, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd165, 8'd165, 8'd165, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd255, 8'd128, 8'd64, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd0, 8'd64, 8'd128, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, rod_pkg::CFG_DITHER_TYPE, 13'(DT_PLAIN), 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL, rod_pkg::CFG_DITHER_TYPE, 13'd0, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [rod_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rod_pkg::CFG_DATA_W-1:0] cfg_data;

  rod_pixel_if  pixels_bus ();
  rod_result_if results_bus ();

  rgb_ordered_dither_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels_bus),
    .results   (results_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and raster position
  logic [3:0]  cfg_type;
  logic [12:0] cfg_width;
  logic [12:0] cfg_height;
  int unsigned col_pos, row_pos, col_ph, row_ph;

  dot_t dots_in_flight [$];

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned frame_ends_seen;
  int unsigned reg_writes;
  int unsigned settings_run;
  logic [15:0] types_used;
  bit          backpressure_done;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Zero acts as one, anything above the maximum saturates
  function automatic int unsigned dim_bound(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return int'(v);
  endfunction

  // Luminance vs. matrix threshold at the current phase, then raster advance
  function automatic dot_t dither_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    int unsigned side, w, h, luma, tx, ty;
    logic [5:0]  idx;
    logic [7:0]  thr;
    logic        row_end, last_row;
    dot_t        d;
    case (cfg_type)
      rod_pkg::DT_THREE_LEVEL, rod_pkg::DT_TWO: side = 2;
      rod_pkg::DT_THREE:                        side = 3;
      rod_pkg::DT_FOUR:                         side = 4;
      rod_pkg::DT_EIGHT:                        side = 8;
      default:                                  side = 1;
    endcase
    w = dim_bound(cfg_width);
    h = dim_bound(cfg_height);
    luma = (32'd19661 * r + 32'd38666 * g + 32'd7209 * b) >> 16;
    // a phase left over from a bigger matrix looks up index 0
    tx = (col_ph < side) ? col_ph : 0;
    ty = (row_ph < side) ? row_ph : 0;
    idx = 6'(ty * side + tx);
    case (cfg_type)
      rod_pkg::DT_THREE_LEVEL: thr = rod_pkg::THR_THREE_LEVEL[idx[1:0]];
      rod_pkg::DT_TWO:         thr = rod_pkg::THR_TWO[idx[1:0]];
      rod_pkg::DT_THREE:       thr = rod_pkg::THR_THREE[idx[3:0]];
      rod_pkg::DT_FOUR:        thr = rod_pkg::THR_FOUR[idx[3:0]];
      rod_pkg::DT_EIGHT:       thr = rod_pkg::THR_EIGHT[idx];
      default:                 thr = rod_pkg::THR_SINGLE;
    endcase
    row_end = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    d.lit = (luma >= 32'(thr));
    d.frame_end = row_end && last_row;
    if (row_end) begin
      col_pos = 0;
      col_ph = 0;
      if (last_row) begin
        row_pos = 0;
        row_ph = 0;
      end else begin
        row_pos++;
        row_ph = (row_ph + 1 >= side) ? 0 : row_ph + 1;
      end
    end else begin
      col_pos++;
      col_ph = (col_ph + 1 >= side) ? 0 : col_ph + 1;
    end
    return d;
  endfunction

  // Mostly short, now and then long
  function automatic int unsigned stall_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [12:0] pick_dim(input int unsigned short_max);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 13'($urandom_range(1, short_max));
    if (roll < 68) return 13'd0;
    if (roll < 78) return 13'($urandom_range(short_max + 1, 300));
    if (roll < 84) return 13'd4096;
    if (roll < 88) return 13'd8191;
    if (roll < 94) return 13'($urandom_range(4097, 8190));
    return 13'($urandom_range(0, 8191));
  endfunction

  function automatic logic [3:0] pick_type();
    if ($urandom_range(0, 9) < 3) return 4'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0:       return rod_pkg::DT_THREE_LEVEL;
      1:       return rod_pkg::DT_TWO;
      2:       return rod_pkg::DT_THREE;
      3:       return rod_pkg::DT_FOUR;
      4:       return rod_pkg::DT_EIGHT;
      default: return rod_pkg::DITHER_TYPE_RST;
    endcase
  endfunction

  // Register write: only once every pixel in flight has come out. Leaves
  // cfg_write high so back-to-back writes never toggle it within a step;
  // the next pixel lowers it.
  task automatic write_reg(input logic [rod_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rod_pkg::CFG_DATA_W-1:0] val);
    pixels_bus.valid <= 1'b0;
    while (dots_in_flight.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rod_pkg::CFG_DITHER_TYPE:  cfg_type = val[3:0];
      rod_pkg::CFG_IMAGE_WIDTH:  cfg_width = val;
      rod_pkg::CFG_IMAGE_HEIGHT: cfg_height = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Offer one pixel, wait for the handshake, then queue its prediction
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic typed, input logic t_lit, input logic t_fe,
                            input bit steady);
    int unsigned gap;
    dot_t pred;
    cfg_write <= 1'b0;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : stall_len();
    if (gap != 0) begin
      pixels_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixels_bus.valid <= 1'b1;
    pixels_bus.red <= r;
    pixels_bus.green <= g;
    pixels_bus.blue <= b;
    @(posedge clk);
    while (!pixels_bus.ready) @(posedge clk);
    types_used[cfg_type] = 1'b1;
    pred = dither_pixel(r, g, b);
    if (typed) begin
      pred.lit = t_lit;
      pred.frame_end = t_fe;
    end
    dots_in_flight.push_back(pred);
    items_sent++;
  endtask

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int unsigned hold_left, steady_left, roll;
    dot_t want;
    hold_left = 0;
    steady_left = 0;
    results_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        results_bus.ready <= 1'b0;
      end else begin
        if (results_bus.valid && results_bus.ready) begin
          if (dots_in_flight.size() == 0) begin
            report_mismatch($sformatf("result lit=%0b frame_end=%0b with no pixel pending",
                                      results_bus.lit, results_bus.frame_end));
          end else begin
            want = dots_in_flight.pop_front();
            if (results_bus.lit !== want.lit)
              report_mismatch($sformatf("result %0d: lit %0b, expected %0b",
                                        results_checked, results_bus.lit, want.lit));
            if (results_bus.frame_end !== want.frame_end)
              report_mismatch($sformatf("result %0d: frame_end %0b, expected %0b",
                                        results_checked, results_bus.frame_end,
                                        want.frame_end));
            if (want.frame_end) frame_ends_seen++;
            results_checked++;
          end
        end
        if (hold_left != 0) begin
          hold_left--;
          results_bus.ready <= 1'b0;
        end else if (!backpressure_done && results_checked >= BACKPRESSURE_AT &&
                     pixels_bus.valid && !pixels_bus.ready) begin
          // long hold-off: the sender keeps offering and the pipe backs up
          backpressure_done = 1'b1;
          hold_left = BACKPRESSURE_LEN - 1;
          results_bus.ready <= 1'b0;
        end else if (steady_left != 0) begin
          steady_left--;
          results_bus.ready <= 1'b1;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            steady_left = $urandom_range(20, 80);
            results_bus.ready <= 1'b1;
          end else if (roll < 20) begin
            hold_left = stall_len() - 1;
            results_bus.ready <= 1'b0;
          end else begin
            results_bus.ready <= 1'b1;
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random settings and pixel runs
  initial begin
    int unsigned random_start, run_len;
    bit steady, gray;
    logic [7:0] r, g, b;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= rod_pkg::CFG_DITHER_TYPE;
    cfg_data <= '0;
    pixels_bus.valid <= 1'b0;
    pixels_bus.red <= 8'd0;
    pixels_bus.green <= 8'd0;
    pixels_bus.blue <= 8'd0;
    cfg_type = rod_pkg::DITHER_TYPE_RST;
    cfg_width = rod_pkg::IMAGE_WIDTH_RST;
    cfg_height = rod_pkg::IMAGE_HEIGHT_RST;
    col_pos = 0;
    row_pos = 0;
    col_ph = 0;
    row_ph = 0;
    fail_count = 0;
    items_sent = 0;
    results_checked = 0;
    frame_ends_seen = 0;
    reg_writes = 0;
    settings_run = 1;
    types_used = '0;
    backpressure_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        write_reg(PLAN[i].index, PLAN[i].value);
        settings_run++;
      end else begin
        send_pixel(PLAN[i].red, PLAN[i].green, PLAN[i].blue,
                   PLAN[i].typed, PLAN[i].lit, PLAN[i].frame_end, 1'b0);
      end
    end

    // Random part: each run picks new settings (sometimes only the matrix,
    // which leaves the raster position mid-frame), then a burst of pixels
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      write_reg(rod_pkg::CFG_DITHER_TYPE, 13'(pick_type()));
      if ($urandom_range(0, 3) != 0) begin
        write_reg(rod_pkg::CFG_IMAGE_WIDTH, pick_dim(12));
        write_reg(rod_pkg::CFG_IMAGE_HEIGHT, pick_dim(6));
      end
      settings_run++;
      steady = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(10, 80);
      repeat (run_len) begin
        // gray pixels give luma == value, landing right on thresholds
        gray = ($urandom_range(0, 3) == 0);
        r = 8'($urandom_range(0, 255));
        g = gray ? r : 8'($urandom_range(0, 255));
        b = gray ? r : 8'($urandom_range(0, 255));
        send_pixel(r, g, b, 1'b0, 1'b0, 1'b0, steady);
      end
    end

    pixels_bus.valid <= 1'b0;
    while (dots_in_flight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d pixels over %0d settings, %0d register writes.",
             results_checked, items_sent, settings_run, reg_writes);
    $display("Saw %0d frame ends, %0d distinct matrix codes, output hold-off %0s.",
             frame_ends_seen, $countones(types_used), backpressure_done ? "done" : "missed");
    if (fail_count == 0) begin
      $display("PASS rgb_ordered_dither_unit");
    end else begin
      $display("FAIL rgb_ordered_dither_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("Timeout with %0d results still pending", dots_in_flight.size());
    $display("FAIL rgb_ordered_dither_unit");
    $finish;
  end

endmodule
